[sv/phb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phb_pkg: shared types and constants for the ps/2 host port bring-up unit
// byte codes, phase and kind encodings, front-to-back item and result beats
// ----------------------------------------------------------------------------
package phb_pkg;

  // send ring per port
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // queue between front and back
  localparam int ITEM_Q_DEPTH = 2;
  localparam int IQ_PTR_W     = $clog2(ITEM_Q_DEPTH);
  localparam int IQ_CNT_W     = $clog2(ITEM_Q_DEPTH + 1);

  // config port
  localparam int CFG_AW = 3;
  localparam logic [0:0] REG_SELF_TEST_OK = 1'b0;

  // device bytes
  localparam logic [7:0] BYTE_ACK         = 8'hFA;
  localparam logic [7:0] BYTE_POST_OK     = 8'hAA;
  localparam logic [7:0] BYTE_KBD_ID      = 8'hAB;
  localparam logic [7:0] BYTE_MOUSE_ID    = 8'h00;
  localparam logic [7:0] BYTE_WHEEL_ID    = 8'h03;

  // host commands
  localparam logic [7:0] CMD_DISABLE_SCAN = 8'hF5;
  localparam logic [7:0] CMD_IDENTIFY     = 8'hF2;
  localparam logic [7:0] CMD_ENABLE_SCAN  = 8'hF4;
  localparam logic [7:0] CMD_RESET        = 8'hFF;

  typedef enum logic [1:0] {
    IN_RX   = 2'd0,
    IN_ENQ  = 2'd1,
    IN_TICK = 2'd2
  } in_cmd_t;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_RX,
    OP_ENQ,
    OP_TICK
  } op_t;

  typedef enum logic [3:0] {
    PH_NONE      = 4'd0,
    PH_RESET_ACK = 4'd1,
    PH_POST      = 4'd2,
    PH_DIS_ACK   = 4'd3,
    PH_ID_ACK    = 4'd4,
    PH_ID_RESP   = 4'd5,
    PH_EN_ACK    = 4'd6,
    PH_READY     = 4'd7,
    PH_FAILED    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_KBD     = 2'd1,
    KIND_MOUSE   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef struct packed {
    op_t        op;
    logic       port;
    logic [7:0] data;
    logic       is_ack;
    logic       is_post_ok;
    logic       is_kbd_id;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic       tx_port;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    phase_t     port_phase;
    kind_t      device_kind;
    logic       queue_overflow;
  } result_t;

  typedef struct packed {
    logic       we;
    logic [1:0] data;
  } cfg_wr_t;

  function automatic kind_t classify(input logic [7:0] first);
    kind_t k;
    if (first == BYTE_KBD_ID) begin
      k = KIND_KBD;
    end else if (first == BYTE_MOUSE_ID || first == BYTE_WHEEL_ID) begin
      k = KIND_MOUSE;
    end else begin
      k = KIND_UNKNOWN;
    end
    return k;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

[sv/phb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phb_front: input beat acceptance and classification
// decodes the command, folds busy ticks and unused codes into idle items,
// and pre-compares the received byte against the sequence bytes
// ----------------------------------------------------------------------------
module phb_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_tuser,
  input  logic [15:0]       in_tdata,
  input  logic              q_full,
  output logic              push,
  output phb_pkg::item_t    push_item
);
  import phb_pkg::*;

  in_cmd_t cmd;
  logic    busy;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;
  assign cmd       = in_cmd_t'(in_tuser[1:0]);
  assign busy      = in_tdata[8];

  always_comb begin
    push_item.port       = in_tuser[2];
    push_item.data       = in_tdata[7:0];
    push_item.is_ack     = (in_tdata[7:0] == BYTE_ACK);
    push_item.is_post_ok = (in_tdata[7:0] == BYTE_POST_OK);
    push_item.is_kbd_id  = (in_tdata[7:0] == BYTE_KBD_ID);
    unique case (cmd)
      IN_RX:   push_item.op = OP_RX;
      IN_ENQ:  push_item.op = OP_ENQ;
      IN_TICK: push_item.op = busy ? OP_IDLE : OP_TICK;
      default: push_item.op = OP_IDLE;
    endcase
  end

endmodule

[sv/phb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phb_queue: short item queue between front and back
// lets the front keep accepting while the back waits on the result side
// ----------------------------------------------------------------------------
module phb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  phb_pkg::item_t push_item,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop_ready,
  output phb_pkg::item_t pop_item
);
  import phb_pkg::*;

  item_t                q_r [ITEM_Q_DEPTH];
  logic [IQ_PTR_W-1:0]  wr_r, wr_nxt;
  logic [IQ_PTR_W-1:0]  rd_r, rd_nxt;
  logic [IQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                 pop;

  assign full      = (cnt_r == IQ_CNT_W'(ITEM_Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = q_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == IQ_PTR_W'(ITEM_Q_DEPTH - 1)) ? '0 : wr_r + IQ_PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == IQ_PTR_W'(ITEM_Q_DEPTH - 1)) ? '0 : rd_r + IQ_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + IQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - IQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_item;
    end
  end

endmodule

[sv/phb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phb_back: per-port bring-up sequencer, send rings and result register
// executes one item per cycle against the port state while the result side is not stalled, and registers the result
// ----------------------------------------------------------------------------
module phb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  phb_pkg::item_t   item,
  input  phb_pkg::cfg_wr_t cfg_wr,
  output logic [1:0]       self_test_ok,
  output logic             res_valid,
  input  logic             res_ready,
  output phb_pkg::result_t res
);
  import phb_pkg::*;

  phase_t            phase_r [2];
  phase_t            phase_nxt [2];
  kind_t             kind_r [2];
  kind_t             kind_nxt [2];
  logic [1:0]        usable_r, usable_nxt;
  logic [1:0]        st_ok_r;
  logic [1:0]        idc_r [2];
  logic [1:0]        idc_nxt [2];
  logic [7:0]        id_r [2][2];
  logic [7:0]        ring_r [2][QUEUE_DEPTH];
  logic [PTR_W-1:0]  rptr_r [2];
  logic [PTR_W-1:0]  rptr_nxt [2];
  logic [PTR_W-1:0]  wptr_r [2];
  logic [PTR_W-1:0]  wptr_nxt [2];
  logic [FILL_W-1:0] fill_r [2];
  logic [FILL_W-1:0] fill_nxt [2];

  logic              out_valid_r;
  result_t           res_r, res_nxt;

  logic              pop;
  logic              snd0, snd1, sends;
  logic              ap;
  phase_t            ph;
  logic              full;
  logic [7:0]        tx_b;
  logic [1:0]        cnt_inc;
  logic              push_req, do_push, rx_fwd, id_we;
  logic [7:0]        push_b;

  assign item_ready   = !out_valid_r || res_ready;
  assign pop          = item_valid && item_ready;
  assign res_valid    = out_valid_r;
  assign res          = res_r;
  assign self_test_ok = st_ok_r;

  always_comb begin
    snd0    = (fill_r[0] != '0) && usable_r[0];
    snd1    = (fill_r[1] != '0) && usable_r[1];
    sends   = (item.op == OP_TICK) && (snd0 || snd1);
    ap      = sends ? !snd0 : item.port;
    ph      = phase_r[ap];
    full    = (fill_r[ap] == FILL_W'(QUEUE_DEPTH));
    tx_b    = ring_r[ap][rptr_r[ap]];
    cnt_inc = idc_r[ap] + 2'd1;

    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    usable_nxt = usable_r;
    idc_nxt    = idc_r;
    rptr_nxt   = rptr_r;
    wptr_nxt   = wptr_r;
    fill_nxt   = fill_r;
    push_req   = 1'b0;
    push_b     = item.data;
    rx_fwd     = 1'b0;
    id_we      = 1'b0;

    unique case (item.op)
      OP_RX: begin
        unique case (ph)
          PH_RESET_ACK: phase_nxt[ap] = item.is_ack ? PH_POST : PH_FAILED;
          PH_POST: begin
            if (item.is_post_ok) begin
              phase_nxt[ap] = PH_DIS_ACK;
              push_req      = 1'b1;
              push_b        = CMD_DISABLE_SCAN;
            end
          end
          PH_DIS_ACK: begin
            if (item.is_ack) begin
              phase_nxt[ap] = PH_ID_ACK;
              push_req      = 1'b1;
              push_b        = CMD_IDENTIFY;
            end
          end
          PH_ID_ACK: begin
            if (item.is_ack) begin
              phase_nxt[ap] = PH_ID_RESP;
              idc_nxt[ap]   = 2'd0;
            end
          end
          PH_ID_RESP: begin
            id_we       = 1'b1;
            idc_nxt[ap] = cnt_inc;
            if (cnt_inc >= 2'd2 || !item.is_kbd_id) begin
              phase_nxt[ap] = PH_EN_ACK;
              push_req      = 1'b1;
              push_b        = CMD_ENABLE_SCAN;
            end
          end
          PH_EN_ACK: begin
            if (item.is_ack) begin
              kind_nxt[ap]   = classify(id_r[ap][0]);
              phase_nxt[ap]  = PH_READY;
              usable_nxt[ap] = 1'b1;
            end
          end
          PH_READY: rx_fwd = 1'b1;
          default: ;
        endcase
      end
      OP_ENQ: push_req = 1'b1;
      OP_TICK: begin
        if (sends) begin
          rptr_nxt[ap] = ptr_inc(rptr_r[ap]);
          fill_nxt[ap] = fill_r[ap] - FILL_W'(1);
          if (tx_b == CMD_RESET) begin
            phase_nxt[ap] = PH_RESET_ACK;
          end
        end
      end
      default: ;
    endcase

    do_push = push_req && !full;
    if (do_push) begin
      wptr_nxt[ap] = ptr_inc(wptr_r[ap]);
      fill_nxt[ap] = fill_r[ap] + FILL_W'(1);
    end

    res_nxt.tx_valid       = sends;
    res_nxt.tx_port        = sends && ap;
    res_nxt.tx_byte        = sends ? tx_b : 8'h00;
    res_nxt.rx_valid       = rx_fwd;
    res_nxt.rx_byte        = rx_fwd ? item.data : 8'h00;
    res_nxt.port_phase     = phase_nxt[ap];
    res_nxt.device_kind    = kind_nxt[ap];
    res_nxt.queue_overflow = push_req && full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '{default: PH_NONE};
      kind_r      <= '{default: KIND_NONE};
      usable_r    <= 2'b11;
      st_ok_r     <= 2'b11;
      idc_r       <= '{default: '0};
      rptr_r      <= '{default: '0};
      wptr_r      <= '{default: '0};
      fill_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        kind_r      <= kind_nxt;
        idc_r       <= idc_nxt;
        rptr_r      <= rptr_nxt;
        wptr_r      <= wptr_nxt;
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr.we) begin
        st_ok_r  <= cfg_wr.data;
        usable_r <= cfg_wr.data;
      end else if (pop) begin
        usable_r <= usable_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
    if (pop && do_push) begin
      ring_r[ap][wptr_r[ap]] <= push_b;
    end
    if (pop && id_we) begin
      id_r[ap][idc_r[ap][0]] <= item.data;
    end
  end

endmodule

[sv/ps2_host_port_bringup_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_port_bringup_unit: two-port ps/2 host bring-up sequencer
//
//   channel  dir  handshake                beat contents
//   in_      in   in_tvalid / in_tready    cmd, port (tuser); byte, busy (tdata)
//   out_     out  out_tvalid / out_tready  one result beat per input beat
//   cfg_     in   apb, pready tied high    self-test-ok mask at offset 0
//
// one beat per cycle sustained while out_tready stays high; a result passes
// through the queue write, then the sequencer and result register
// a two-beat queue sits between classification and the sequencer
// in_tready drops only while that queue is full behind a stalled out_ side
// synchronous active-low reset; send rings and identify bytes are not cleared
// ----------------------------------------------------------------------------
module ps2_host_port_bringup_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [2:0]                 in_tuser,   // cmd[1:0], port[2]
  input  logic [15:0]                in_tdata,   // data_byte[7:0], controller_busy[8]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // tx_valid[0], tx_port[1], tx_byte[9:2],
                                                 // rx_valid[10], rx_byte[18:11],
                                                 // port_phase[22:19], device_kind[24:23],
                                                 // queue_overflow[25]
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [phb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import phb_pkg::*;

  logic       q_full;
  logic       push;
  item_t      push_item;
  logic       pop_valid;
  logic       pop_ready;
  item_t      pop_item;
  cfg_wr_t    cfg_wr;
  logic [1:0] st_ok;
  result_t    res;
  logic       reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_SELF_TEST_OK);
  assign cfg_wr.we  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit;
  assign cfg_wr.data = cfg_pwdata[1:0];
  assign cfg_prdata = reg_hit ? {30'd0, st_ok} : 32'd0;

  assign out_tdata = {6'd0, res.queue_overflow, res.device_kind, res.port_phase,
                      res.rx_byte, res.rx_valid, res.tx_byte, res.tx_port, res.tx_valid};

  phb_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  phb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  phb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (pop_valid),
    .item_ready   (pop_ready),
    .item         (pop_item),
    .cfg_wr       (cfg_wr),
    .self_test_ok (st_ok),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res          (res)
  );

endmodule

[sv/phb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phb_checker: port-level checks for the ps/2 host port bring-up unit
// result beat consistency and output hold under stall
// ----------------------------------------------------------------------------
module phb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_tx_rx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[10]))
    else $error("send and forward in one beat");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[9:1] == 9'd0)
    else $error("send fields set without a send");

  a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[10] |-> out_tdata[18:11] == 8'd0)
    else $error("forward byte set without a forward");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:19] <= 4'd8)
    else $error("port phase out of range");

endmodule

bind ps2_host_port_bringup_unit phb_checker u_phb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
